// File: rtl/uavkv_pkg.sv
// shared types and constants for the unsorted key-value table
package uavkv_pkg;

    localparam int DATA_W = 32;

    // request codes
    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_LOOKUP = 2'd1;
    localparam logic [1:0] REQ_REMOVE = 2'd2;
    localparam logic [1:0] REQ_NOP    = 2'd3;

    // register select, taken from paddr bit 2
    localparam logic REG_ABSENT = 1'b0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SHIFT,
        ST_MISS,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic rd_en;
        logic cap_hit;
        logic wr_hit;
        logic shift_wr;
        logic append;
        logic dec;
        logic reject;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        logic       dv;
        logic       match;
        logic       last;
        logic       more;
        logic       full;
        logic       empty;
        logic [1:0] req;
    } t_dp_sts;

endpackage

// File: rtl/uavkv_dp.sv
// datapath: key and value memories, scan pointer, entry count and result registers
module uavkv_dp
    import uavkv_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_dp_cmd                   i_cmd,
    output t_dp_sts                   o_sts,
    input  logic [1:0]                i_req_type,
    input  logic [DATA_W-1:0]         i_key,
    input  logic [DATA_W-1:0]         i_value,
    input  logic [DATA_W-1:0]         i_absent,
    output logic                      o_strobe,
    output logic signed [DATA_W-1:0]  o_result_value,
    output logic                      o_hit,
    output logic                      o_full_reject,
    output logic [4:0]                o_entry_count,
    output logic                      o_is_empty
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int EXT_W = (CNT_W > 5) ? CNT_W : 5;

    logic [DATA_W-1:0] key_mem [DEPTH];
    logic [DATA_W-1:0] val_mem [DEPTH];

    logic [1:0]        r_req;
    logic [DATA_W-1:0] r_key;
    logic [DATA_W-1:0] r_val;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  r_rd_addr;
    logic              r_dv;
    logic [IDX_W-1:0]  r_d_idx;
    logic [DATA_W-1:0] r_mkey;
    logic [DATA_W-1:0] r_mval;
    logic [DATA_W-1:0] r_old;
    logic              r_hit;
    logic              r_reject;

    logic              key_we;
    logic              val_we;
    logic [IDX_W-1:0]  wr_addr;
    logic [DATA_W-1:0] wr_key;
    logic [DATA_W-1:0] wr_val;
    logic [EXT_W-1:0]  cnt_ext;

    assign cnt_ext = EXT_W'(r_count);

    // status toward the controller
    always_comb begin
        o_sts.dv    = r_dv;
        o_sts.match = r_dv && (r_mkey == r_key);
        o_sts.last  = (CNT_W'(r_d_idx) + CNT_W'(1)) == r_count;
        o_sts.more  = r_rd_addr < r_count;
        o_sts.full  = r_count == CNT_W'(DEPTH);
        o_sts.empty = r_count == '0;
        o_sts.req   = r_req;
    end

    // single write port: update in place, shift down by one, or append
    always_comb begin
        key_we  = i_cmd.shift_wr || i_cmd.append;
        val_we  = i_cmd.shift_wr || i_cmd.append || i_cmd.wr_hit;
        wr_addr = r_d_idx;
        wr_key  = r_key;
        wr_val  = r_val;
        if (i_cmd.shift_wr) begin
            wr_addr = r_d_idx - IDX_W'(1);
            wr_key  = r_mkey;
            wr_val  = r_mval;
        end else if (i_cmd.append) begin
            wr_addr = r_count[IDX_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (key_we) begin
            key_mem[wr_addr] <= wr_key;
        end
        if (val_we) begin
            val_mem[wr_addr] <= wr_val;
        end
        if (i_cmd.rd_en) begin
            r_mkey  <= key_mem[r_rd_addr[IDX_W-1:0]];
            r_mval  <= val_mem[r_rd_addr[IDX_W-1:0]];
            r_d_idx <= r_rd_addr[IDX_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_dv     <= 1'b0;
            o_strobe <= 1'b0;
        end else begin
            r_dv     <= i_cmd.rd_en;
            o_strobe <= i_cmd.emit;
            if (i_cmd.append) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_cmd.dec) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req     <= i_req_type;
            r_key     <= i_key;
            r_val     <= i_value;
            r_rd_addr <= '0;
            r_hit     <= 1'b0;
            r_reject  <= 1'b0;
        end else if (i_cmd.rd_en) begin
            r_rd_addr <= r_rd_addr + CNT_W'(1);
        end
        if (i_cmd.cap_hit) begin
            r_old <= r_mval;
            r_hit <= 1'b1;
        end
        if (i_cmd.reject) begin
            r_reject <= 1'b1;
        end
        if (i_cmd.emit) begin
            o_result_value <= r_hit ? r_old : i_absent;
            o_hit          <= r_hit;
            o_full_reject  <= r_reject;
            o_entry_count  <= cnt_ext[4:0];
            o_is_empty     <= r_count == '0;
        end
    end

endmodule

// File: rtl/uavkv_ctrl.sv
// controller: sequences scan, shift-down, append and result for each request
module uavkv_ctrl
    import uavkv_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  logic [1:0] i_req_type,
    input  t_dp_sts    i_sts,
    output t_dp_cmd    o_cmd,
    output logic       o_busy
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_busy  = 1'b1;
        case (r_state)
            ST_IDLE: begin
                o_busy = 1'b0;
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    if (i_req_type == REQ_NOP) begin
                        n_state = ST_DONE;
                    end else if (i_sts.empty) begin
                        n_state = ST_MISS;
                    end else begin
                        n_state = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                // reads run one entry ahead of the compare
                o_cmd.rd_en = i_sts.more;
                if (i_sts.match) begin
                    o_cmd.cap_hit = 1'b1;
                    case (i_sts.req)
                        REQ_INSERT: begin
                            o_cmd.wr_hit = 1'b1;
                            n_state      = ST_DONE;
                        end
                        REQ_REMOVE: begin
                            if (i_sts.last) begin
                                o_cmd.dec = 1'b1;
                                n_state   = ST_DONE;
                            end else begin
                                n_state = ST_SHIFT;
                            end
                        end
                        default: begin
                            n_state = ST_DONE;
                        end
                    endcase
                end else if (i_sts.dv && i_sts.last) begin
                    n_state = ST_MISS;
                end
            end
            ST_SHIFT: begin
                // each entry read moves down one place
                o_cmd.rd_en = i_sts.more;
                if (i_sts.dv) begin
                    o_cmd.shift_wr = 1'b1;
                    if (i_sts.last) begin
                        o_cmd.dec = 1'b1;
                        n_state   = ST_DONE;
                    end
                end
            end
            ST_MISS: begin
                if (i_sts.req == REQ_INSERT) begin
                    if (i_sts.full) begin
                        o_cmd.reject = 1'b1;
                    end else begin
                        o_cmd.append = 1'b1;
                    end
                end
                n_state = ST_DONE;
            end
            ST_DONE: begin
                o_cmd.emit = 1'b1;
                n_state    = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/unsorted_array_key_value_table_top.sv
// unsorted key-value table: config register, controller and memory datapath
// a hit at position p ends the scan there, a miss compares all N entries held, and a remove
// hit then shifts the later entries down; an empty table skips the scan, an unused code does no work;
// the single read port of the key memory scans and shifts one entry per cycle.
// a new word is taken in the cycle its predecessor's result strobe shows; no output stall.
// synchronous reset empties the table and clears absent_value; no clearing pass.
module unsorted_array_key_value_table_top
    import uavkv_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [1:0]                i_req_type,
    input  logic signed [DATA_W-1:0]  i_key,
    input  logic signed [DATA_W-1:0]  i_value,
    output logic                      o_strobe,
    output logic signed [DATA_W-1:0]  o_result_value,
    output logic                      o_hit,
    output logic                      o_full_reject,
    output logic [4:0]                o_entry_count,
    output logic                      o_is_empty,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [2:0]                paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready
);

    logic [DATA_W-1:0] r_absent;
    t_dp_cmd           cmd;
    t_dp_sts           sts;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_ABSENT) ? r_absent : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_absent <= '0;
        end else if (psel && penable && pwrite && pready && (paddr[2] == REG_ABSENT)) begin
            r_absent <= pwdata;
        end
    end

    uavkv_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_req_type (i_req_type),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_busy     (busy)
    );

    uavkv_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_req_type     (i_req_type),
        .i_key          (i_key),
        .i_value        (i_value),
        .i_absent       (r_absent),
        .o_strobe       (o_strobe),
        .o_result_value (o_result_value),
        .o_hit          (o_hit),
        .o_full_reject  (o_full_reject),
        .o_entry_count  (o_entry_count),
        .o_is_empty     (o_is_empty)
    );

    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("result strobe held for more than one cycle");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted word did not raise busy");

    a_reject_no_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_full_reject) |-> !o_hit)
        else $error("full reject reported together with a hit");

    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_is_empty) |-> (o_entry_count == 5'd0))
        else $error("empty flag with nonzero entry count");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(sts.full && cmd.append))
        else $error("append into a full table");

endmodule

// File: bench/unsorted_array_key_value_table_top_tb.sv
// self-checking bench for the unsorted key-value table: directed and random requests
`timescale 1ns / 100ps

module unsorted_array_key_value_table_top_tb;
    import uavkv_pkg::*;

    localparam int TABLE_DEPTH = 16;
    localparam int POOL_SIZE   = 24;
    localparam int PHASES      = 8;
    localparam int PHASE_WORDS = 160;
    localparam int MAX_PRINTS  = 40;

    localparam logic [2:0] ADDR_ABSENT = 3'd0;
    localparam logic [2:0] ADDR_UNUSED = 3'd4;

    typedef struct {
        logic [1:0]         req;
        logic signed [31:0] key;
        logic signed [31:0] value;
    } t_request;

    typedef struct {
        logic signed [31:0] value;
        logic               hit;
        logic               reject;
        logic [4:0]         count;
        logic               empty;
    } t_answer;

    logic               i_clk          = 1'b0;
    logic               i_rst_n        = 1'b0;
    logic               start          = 1'b0;
    logic               busy;
    logic [1:0]         i_req_type     = REQ_NOP;
    logic signed [31:0] i_key          = '0;
    logic signed [31:0] i_value        = '0;
    logic               o_strobe;
    logic signed [31:0] o_result_value;
    logic               o_hit;
    logic               o_full_reject;
    logic [4:0]         o_entry_count;
    logic               o_is_empty;
    logic               psel           = 1'b0;
    logic               penable        = 1'b0;
    logic               pwrite         = 1'b0;
    logic [2:0]         paddr          = '0;
    logic [31:0]        pwdata         = '0;
    logic [31:0]        prdata;
    logic               pready;

    // table copy kept by the bench
    logic signed [31:0] shadow_keys   [TABLE_DEPTH];
    logic signed [31:0] shadow_values [TABLE_DEPTH];
    int                 shadow_count  = 0;
    logic signed [31:0] absent_cfg    = '0;

    t_request           pending_words [$];
    t_answer            answers_due   [$];
    t_request           word_now;
    int                 idle_left     = 0;
    logic               calm          = 1'b0;
    int                 mismatch_count = 0;
    logic signed [31:0] key_pool [POOL_SIZE];

    unsorted_array_key_value_table_top #(
        .DEPTH (TABLE_DEPTH)
    ) u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_req_type     (i_req_type),
        .i_key          (i_key),
        .i_value        (i_value),
        .o_strobe       (o_strobe),
        .o_result_value (o_result_value),
        .o_hit          (o_hit),
        .o_full_reject  (o_full_reject),
        .o_entry_count  (o_entry_count),
        .o_is_empty     (o_is_empty),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTS) begin
            $display("mismatch %s: got %h, expected %h at %0t", what, got, want, $time);
        end
    endtask

    // apply one accepted request to the table copy and queue its answer
    task automatic predict_request(input t_request w);
        t_answer a;
        int      slot;
        a.value  = absent_cfg;
        a.hit    = 1'b0;
        a.reject = 1'b0;
        slot     = -1;
        if (w.req != REQ_NOP) begin
            for (int i = 0; i < shadow_count; i++) begin
                if (slot < 0 && shadow_keys[i] == w.key) begin
                    slot = i;
                end
            end
            if (slot >= 0) begin
                a.hit   = 1'b1;
                a.value = shadow_values[slot];
                if (w.req == REQ_INSERT) begin
                    shadow_values[slot] = w.value;
                end else if (w.req == REQ_REMOVE) begin
                    // close the gap, later entries keep their order
                    for (int j = slot; j < shadow_count - 1; j++) begin
                        shadow_keys[j]   = shadow_keys[j + 1];
                        shadow_values[j] = shadow_values[j + 1];
                    end
                    shadow_count--;
                end
            end else if (w.req == REQ_INSERT) begin
                if (shadow_count < TABLE_DEPTH) begin
                    shadow_keys[shadow_count]   = w.key;
                    shadow_values[shadow_count] = w.value;
                    shadow_count++;
                end else begin
                    a.reject = 1'b1;
                end
            end
        end
        a.count = 5'(shadow_count);
        a.empty = (shadow_count == 0);
        answers_due.push_back(a);
    endtask

    always @(posedge i_clk) begin : drive_proc
        logic go;
        if (!i_rst_n) begin
            start     <= 1'b0;
            idle_left <= 0;
        end else begin
            go = start;
            if (start && !busy) begin
                predict_request(word_now);
                go = 1'b0;
            end
            if (!go && idle_left == 0 && pending_words.size() > 0) begin
                word_now = pending_words.pop_front();
                go = 1'b1;
                if ($urandom_range(0, 29) == 0) begin
                    calm = !calm;
                end
                idle_left <= calm ? 0 : $urandom_range(0, 6);
            end else if (!go && idle_left > 0 && !busy) begin
                idle_left <= idle_left - 1;
            end
            start <= go;
            if (go) begin
                i_req_type <= word_now.req;
                i_key      <= word_now.key;
                i_value    <= word_now.value;
            end else begin
                // junk on the payload while no word is offered
                i_req_type <= 2'($urandom);
                i_key      <= $urandom;
                i_value    <= $urandom;
            end
        end
    end

    always @(posedge i_clk) begin : check_proc
        t_answer want;
        if (i_rst_n && o_strobe) begin
            if (answers_due.size() == 0) begin
                report_mismatch("unexpected result", o_result_value, '0);
            end else begin
                want = answers_due.pop_front();
                if (o_result_value !== want.value) begin
                    report_mismatch("result_value", o_result_value, want.value);
                end
                if (o_hit !== want.hit) begin
                    report_mismatch("hit", 32'(o_hit), 32'(want.hit));
                end
                if (o_full_reject !== want.reject) begin
                    report_mismatch("full_reject", 32'(o_full_reject), 32'(want.reject));
                end
                if (o_entry_count !== want.count) begin
                    report_mismatch("entry_count", 32'(o_entry_count), 32'(want.count));
                end
                if (o_is_empty !== want.empty) begin
                    report_mismatch("is_empty", 32'(o_is_empty), 32'(want.empty));
                end
            end
        end
    end

    task automatic add_word(input logic [1:0] req, input logic [31:0] key,
                            input logic [31:0] value);
        t_request w;
        w.req   = req;
        w.key   = key;
        w.value = value;
        pending_words.push_back(w);
    endtask

    task automatic write_register(input logic [2:0] addr, input logic [31:0] data);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_ABSENT) begin
            absent_cfg = data;
        end
    endtask

    // sampled at the falling edge so the clocked blocks have settled
    task automatic wait_idle();
        @(negedge i_clk);
        while (pending_words.size() > 0 || answers_due.size() > 0 || start || busy) begin
            @(negedge i_clk);
        end
    endtask

    task automatic add_random_word(input int ins_pct, input int rem_pct);
        int          r;
        logic [1:0]  req;
        logic [31:0] key;
        logic [31:0] value;
        r = $urandom_range(0, 99);
        if (r < 4) begin
            req = REQ_NOP;
        end else if (r < 4 + ins_pct) begin
            req = REQ_INSERT;
        end else if (r < 4 + ins_pct + rem_pct) begin
            req = REQ_REMOVE;
        end else begin
            req = REQ_LOOKUP;
        end
        key   = ($urandom_range(0, 99) < 85) ? key_pool[$urandom_range(0, POOL_SIZE - 1)]
                                             : $urandom;
        value = $urandom;
        if ($urandom_range(0, 19) == 0) begin
            value = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
        end
        add_word(req, key, value);
    endtask

    initial begin : stimulus_proc
        logic [31:0] absent_plan [PHASES];
        int          ins_pct;
        int          rem_pct;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty table, extremes, update, shift on remove, full table
        add_word(REQ_LOOKUP, 32'd0, 32'd0);
        add_word(REQ_REMOVE, 32'd5, 32'd0);
        add_word(REQ_NOP, 32'd0, 32'hffff_ffff);
        add_word(REQ_INSERT, 32'h8000_0000, 32'h7fff_ffff);
        add_word(REQ_INSERT, 32'h7fff_ffff, 32'h8000_0000);
        add_word(REQ_INSERT, 32'd0, 32'd0);
        add_word(REQ_INSERT, 32'hffff_ffff, 32'hffff_ffff);
        add_word(REQ_INSERT, 32'h8000_0000, 32'h1234_5678);
        add_word(REQ_LOOKUP, 32'h7fff_ffff, 32'd0);
        add_word(REQ_LOOKUP, 32'd1, 32'd0);
        add_word(REQ_REMOVE, 32'h7fff_ffff, 32'd0);
        add_word(REQ_LOOKUP, 32'd0, 32'd0);
        for (int i = 0; i < TABLE_DEPTH - 3; i++) begin
            add_word(REQ_INSERT, 32'd100 + i, $urandom);
        end
        add_word(REQ_INSERT, 32'd999, 32'd7);
        add_word(REQ_INSERT, 32'hffff_ffff, 32'd3);
        add_word(REQ_REMOVE, 32'h8000_0000, 32'd0);
        wait_idle();

        absent_plan[0] = 32'h7fff_ffff;
        absent_plan[1] = 32'h8000_0000;
        absent_plan[2] = 32'hffff_ffff;
        absent_plan[3] = 32'd0;
        absent_plan[4] = $urandom;
        absent_plan[5] = 32'd1;
        absent_plan[6] = $urandom;
        absent_plan[7] = $urandom;

        for (int p = 0; p < PHASES; p++) begin
            write_register(ADDR_ABSENT, absent_plan[p]);
            if (p == 3) begin
                // no register behind this address, absent value must hold
                write_register(ADDR_UNUSED, $urandom);
            end
            key_pool[0] = 32'h8000_0000;
            key_pool[1] = 32'h7fff_ffff;
            key_pool[2] = 32'd0;
            key_pool[3] = 32'hffff_ffff;
            for (int k = 4; k < POOL_SIZE; k++) begin
                key_pool[k] = $urandom;
            end
            for (int n = 0; n < PHASE_WORDS; n++) begin
                // bias swings between filling and draining the table
                if (n % 40 == 0) begin
                    case ($urandom_range(0, 2))
                        0: begin
                            ins_pct = 65;
                            rem_pct = 15;
                        end
                        1: begin
                            ins_pct = 20;
                            rem_pct = 55;
                        end
                        default: begin
                            ins_pct = 40;
                            rem_pct = 30;
                        end
                    endcase
                end
                add_random_word(ins_pct, rem_pct);
            end
            wait_idle();
        end

        repeat (25) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("unsorted_array_key_value_table_top_tb: PASS");
        end else begin
            $display("unsorted_array_key_value_table_top_tb: FAIL");
        end
        $finish;
    end

    initial begin : watchdog_proc
        #5_000_000;
        $display("unsorted_array_key_value_table_top_tb: FAIL");
        $finish;
    end

endmodule
